/* design/cchr_pkg.sv */
// ----------------------------------------------------------------------------
// cchr_pkg
// Shared types, codes and helpers for the capacitor charge regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cchr_pkg;

    localparam int TIME_BITS = 32;
    localparam int VOLT_W    = 16;
    localparam int HYST_W    = 10;
    localparam int BAND_W    = VOLT_W + HYST_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 9;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // op codes carried in tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PULSE = 2'd2;
    localparam logic [1:0] OP_OFF   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READY_WAIT = 3'd4;

    // external codes on the result
    localparam logic [1:0] DEV_CODE_OFF      = 2'd0;
    localparam logic [1:0] DEV_CODE_CHARGING = 2'd1;
    localparam logic [1:0] DEV_CODE_READY    = 2'd2;
    localparam logic [1:0] DEV_CODE_FAULT    = 2'd3;
    localparam logic [1:0] MODE_CODE_HOLD      = 2'd0;
    localparam logic [1:0] MODE_CODE_DISCHARGE = 2'd1;
    localparam logic [1:0] MODE_CODE_CHARGE    = 2'd2;

    typedef enum logic [3:0] {
        DEV_OFF      = 4'b0001,
        DEV_CHARGING = 4'b0010,
        DEV_READY    = 4'b0100,
        DEV_FAULT    = 4'b1000
    } t_dev_state;

    typedef enum logic [2:0] {
        MODE_HOLD      = 3'b001,
        MODE_DISCHARGE = 3'b010,
        MODE_CHARGE    = 3'b100
    } t_bank_mode;

    // band compare results, D against +/-M
    typedef struct packed {
        logic ge_m;      // D >= M
        logic lt_neg_m;  // D < -M
        logic le_neg_m;  // D <= -M
    } t_band;

    // saturating time + millisecond offset
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [CFG_W-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {{(TIME_BITS + 1 - CFG_W){1'b0}}, b};
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/cchr_band.sv */
// ----------------------------------------------------------------------------
// cchr_band
// Hysteresis band compare: D = (T - A) * 1000 against M = H * T.
// ----------------------------------------------------------------------------
`default_nettype none

module cchr_band
    import cchr_pkg::*;
(
    input  wire logic [VOLT_W-1:0] i_target,
    input  wire logic [VOLT_W-1:0] i_sample,
    input  wire logic [BAND_W-1:0] i_band,
    output t_band                  o_band
);

    localparam int DIFF_W = VOLT_W + 1;
    localparam int ERR_W  = BAND_W + 2;

    logic signed [DIFF_W-1:0] diff;
    logic signed [ERR_W-1:0]  diff_x;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  m_pos;
    logic signed [ERR_W-1:0]  m_neg;

    assign diff   = $signed({1'b0, i_target}) - $signed({1'b0, i_sample});
    assign diff_x = {{(ERR_W - DIFF_W){diff[DIFF_W-1]}}, diff};
    // x1000 as 1024 - 16 - 8
    assign err    = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
    assign m_pos  = $signed({2'b00, i_band});
    assign m_neg  = -m_pos;

    assign o_band.ge_m     = (err >= m_pos);
    assign o_band.lt_neg_m = (err <  m_neg);
    assign o_band.le_neg_m = (err <= m_neg);

endmodule

`default_nettype wire

/* design/capacitor_charge_hysteresis_regulator_unit.sv */
// ----------------------------------------------------------------------------
// capacitor_charge_hysteresis_regulator_unit
// Capacitor bank charge regulator with per-mille error hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one event per transaction: tuser[1:0] is the op
//    (tick with sample, start charge, pulse finished, reset to off) and
//    tdata[15:0] the bank voltage sample, looked at on ticks only.
//  - Master stream returns exactly one result transaction per event, in
//    order, packed in tdata as listed at the port.
//  - Registers are written through i_cfg_we/i_cfg_index/i_cfg_wdata, one
//    per clock, while no event is in flight: a rule the user is bound to,
//    which the block itself does not enforce.
//  - Each event passes the input register, then the result register.
//  - Throughput: one event per cycle while the master takes results, set by
//    the single regulation pass between the input and result registers.
//  - A stalled master holds its result; the input register still takes one
//    more event, then tready drops until the result is taken.
//  - Synchronous active-low reset: device off, discharge switch on, tick
//    count and deadlines zero, setpoint 1, other registers 0.
// ----------------------------------------------------------------------------
`default_nettype none

module capacitor_charge_hysteresis_regulator_unit
    import cchr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // event stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // [15:0] measured_voltage
    input  wire logic [1:0]           s_axis_tuser,  // [1:0] op
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [0] supply_enable, [1] discharge_enable, [3:2] device_state,
    // [5:4] charge_mode, [6] voltage_ready, [7] battery_fault,
    // [8] request_rejected, [15:9] zero
    output logic [15:0]               m_axis_tdata
);

    // configuration registers
    logic [VOLT_W-1:0] r_setpoint;
    logic [HYST_W-1:0] r_hyst;
    logic [CFG_W-1:0]  r_timeout;
    logic [CFG_W-1:0]  r_supply_off;
    logic [CFG_W-1:0]  r_ready_wait;

    // input register
    logic              r_in_valid;
    logic [1:0]        r_in_op;
    logic [VOLT_W-1:0] r_in_sample;

    // regulator state
    t_dev_state        r_dev,   n_dev;
    t_bank_mode        r_mode,  n_mode;
    logic              r_ready, n_ready;
    logic              r_sup,   n_sup;
    logic              r_dis,   n_dis;
    logic [VOLT_W-1:0] r_target, n_target;
    logic [BAND_W-1:0] r_band,   n_band;    // H * T, kept alongside T
    logic [TIME_BITS-1:0] r_tick, n_tick;
    logic [TIME_BITS-1:0] r_cdl,  n_cdl;    // charge deadline
    logic [TIME_BITS-1:0] r_sodl, n_sodl;   // supply-off deadline
    logic [TIME_BITS-1:0] r_rdl,  n_rdl;    // ready deadline

    // result register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              advance;
    logic              fault_now;
    logic              rejected;
    logic [TIME_BITS-1:0] tick_inc;
    logic [1:0]        dev_code;
    logic [1:0]        mode_code;
    t_band             band;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - OUT_W){1'b0}}, r_out_data};

    cchr_band u_band (
        .i_target (r_target),
        .i_sample (r_in_sample),
        .i_band   (r_band),
        .o_band   (band)
    );

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= VOLT_W'(1);
            r_hyst       <= '0;
            r_timeout    <= '0;
            r_supply_off <= '0;
            r_ready_wait <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SETPOINT:   r_setpoint   <= i_cfg_wdata;
                REG_HYST:       r_hyst       <= i_cfg_wdata[HYST_W-1:0];
                REG_TIMEOUT:    r_timeout    <= i_cfg_wdata;
                REG_SUPPLY_OFF: r_supply_off <= i_cfg_wdata;
                REG_READY_WAIT: r_ready_wait <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op     <= s_axis_tuser;
            r_in_sample <= s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // event handling, one pass per transaction
    // ------------------------------------------------------------------
    assign tick_inc = (r_tick != TIME_MAX) ? r_tick + TIME_BITS'(1) : r_tick;

    always_comb begin
        n_dev     = r_dev;
        n_mode    = r_mode;
        n_ready   = r_ready;
        n_sup     = r_sup;
        n_dis     = r_dis;
        n_target  = r_target;
        n_band    = r_band;
        n_tick    = r_tick;
        n_cdl     = r_cdl;
        n_sodl    = r_sodl;
        n_rdl     = r_rdl;
        fault_now = 1'b0;
        rejected  = 1'b0;

        if (advance) begin
            case (r_in_op)
                OP_TICK: begin
                    n_tick = tick_inc;
                    // regulate only once the post-pulse pause is over
                    if ((r_dev == DEV_CHARGING || r_dev == DEV_READY) &&
                        tick_inc > r_sodl) begin
                        unique case (r_mode)
                            MODE_HOLD: begin
                                n_ready = 1'b0;
                                n_sup   = 1'b0;
                                n_dis   = 1'b0;
                                if (band.ge_m) begin
                                    n_cdl  = sat_add(tick_inc, r_timeout);
                                    n_mode = MODE_CHARGE;
                                end else if (band.lt_neg_m) begin
                                    n_mode = MODE_DISCHARGE;
                                end else begin
                                    n_ready = 1'b1;
                                end
                            end
                            MODE_DISCHARGE: begin
                                n_sup = 1'b0;
                                n_dis = 1'b1;
                                if (!band.lt_neg_m) begin
                                    n_mode = MODE_HOLD;
                                end
                            end
                            default: begin
                                n_sup = 1'b1;
                                n_dis = 1'b0;
                                if (band.le_neg_m) begin
                                    n_mode = MODE_HOLD;
                                end
                            end
                        endcase
                    end
                    if (r_dev == DEV_CHARGING) begin
                        if (n_ready && tick_inc > r_rdl) begin
                            n_dev = DEV_READY;
                        end
                        // charge timeout wins over ready
                        if (n_mode == MODE_CHARGE && tick_inc > n_cdl) begin
                            n_sup     = 1'b0;
                            n_dis     = 1'b1;
                            n_dev     = DEV_FAULT;
                            fault_now = 1'b1;
                        end
                    end
                end
                OP_START: begin
                    if (r_dev == DEV_OFF || r_dev == DEV_READY) begin
                        n_target = r_setpoint;
                        n_band   = {{HYST_W{1'b0}}, r_setpoint} *
                                   {{VOLT_W{1'b0}}, r_hyst};
                        n_mode   = MODE_HOLD;
                        n_dev    = DEV_CHARGING;
                    end else if (r_dev == DEV_FAULT) begin
                        rejected = 1'b1;
                    end
                end
                OP_PULSE: begin
                    if (r_dev == DEV_READY) begin
                        n_sodl   = sat_add(r_tick, r_supply_off);
                        n_rdl    = sat_add(r_tick, r_ready_wait);
                        n_target = r_setpoint;
                        n_band   = {{HYST_W{1'b0}}, r_setpoint} *
                                   {{VOLT_W{1'b0}}, r_hyst};
                        n_mode   = MODE_HOLD;
                        n_dev    = DEV_CHARGING;
                    end else begin
                        rejected = 1'b1;
                    end
                end
                default: begin
                    n_sup = 1'b0;
                    n_dis = 1'b1;
                    n_dev = DEV_OFF;
                end
            endcase
        end else if (i_cfg_we && i_cfg_index == REG_HYST) begin
            // keep H * T current when H is written under a latched target and no event advances
            n_band = {{VOLT_W{1'b0}}, i_cfg_wdata[HYST_W-1:0]} *
                     {{HYST_W{1'b0}}, r_target};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev    <= DEV_OFF;
            r_mode   <= MODE_HOLD;
            r_ready  <= 1'b0;
            r_sup    <= 1'b0;
            r_dis    <= 1'b1;
            r_target <= '0;
            r_band   <= '0;
            r_tick   <= '0;
            r_cdl    <= '0;
            r_sodl   <= '0;
            r_rdl    <= '0;
        end else begin
            r_dev    <= n_dev;
            r_mode   <= n_mode;
            r_ready  <= n_ready;
            r_sup    <= n_sup;
            r_dis    <= n_dis;
            r_target <= n_target;
            r_band   <= n_band;
            r_tick   <= n_tick;
            r_cdl    <= n_cdl;
            r_sodl   <= n_sodl;
            r_rdl    <= n_rdl;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb begin
        unique case (n_dev)
            DEV_OFF:      dev_code = DEV_CODE_OFF;
            DEV_CHARGING: dev_code = DEV_CODE_CHARGING;
            DEV_READY:    dev_code = DEV_CODE_READY;
            DEV_FAULT:    dev_code = DEV_CODE_FAULT;
            default:      dev_code = DEV_CODE_OFF;
        endcase
        unique case (n_mode)
            MODE_HOLD:      mode_code = MODE_CODE_HOLD;
            MODE_DISCHARGE: mode_code = MODE_CODE_DISCHARGE;
            MODE_CHARGE:    mode_code = MODE_CODE_CHARGE;
            default:        mode_code = MODE_CODE_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {rejected, fault_now, n_ready, mode_code, dev_code,
                           n_dis, n_sup};
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // supply and discharge switch never on together
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sup && r_dis))
        else $error("supply and discharge both enabled");

    // a timeout fault result always reports the fault state with supply off
    a_fault_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |->
            (m_axis_tdata[3:2] == DEV_CODE_FAULT && !m_axis_tdata[0]))
        else $error("fault result without fault state");

    // the tick counter saturates and never wraps back to zero
    a_tick_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick != '0) |=> (r_tick != '0))
        else $error("tick counter wrapped");

    // a rejected request never coincides with a fault being raised
    a_reject_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> !(rejected && fault_now))
        else $error("rejection and fault on one transaction");

endmodule

`default_nettype wire
